### design/rgbfx_pkg.sv
// rgbfx_pkg: shared types, command codes and the raised-sine table for the rgb led effect
// controller. Depends on nothing; every other design file imports it.
package rgbfx_pkg;

    localparam int SINE_ENTRIES         = 256;
    localparam int SINE_IDX_W           = $clog2(SINE_ENTRIES);
    localparam int SYSTEM_BLINK_TOGGLES = 6;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_STATIC  = 3'd1;
    localparam logic [2:0] CMD_BLINK   = 3'd2;
    localparam logic [2:0] CMD_PULSE   = 3'd3;
    localparam logic [2:0] CMD_OFF     = 3'd4;
    localparam logic [2:0] CMD_RELEASE = 3'd5;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TICK,
        OP_APPLY,
        OP_RELEASE
    } op_t;

    typedef enum logic [1:0] {
        EFF_NONE  = 2'd0,
        EFF_BLINK = 2'd1,
        EFF_PULSE = 2'd2
    } effect_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  cmd;
        logic [23:0] colour;
        logic [15:0] time_ms;
        logic        from_system;
    } rgbfx_item_t;

    typedef logic [7:0] sine_tab_t [SINE_ENTRIES];

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // sin over a quarter wave in q30, truncating taylor series up to x^13
    function automatic logic [63:0] quarter_sine(input logic [63:0] r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [64:0] sum;
        x   = (HALF_PI_Q30 * r) / SINE_ENTRIES;
        x2  = (x * x) >> 30;
        t   = x;
        sum = $signed({1'b0, x});
        for (int n = 0; n < 6; n++) begin
            t = (t * x2) >> 30;
            t = t / TAYLOR_DIV[n];
            if (n % 2 == 0) begin
                sum = sum - $signed({1'b0, t});
            end else begin
                sum = sum + $signed({1'b0, t});
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        if (sum > $signed({1'b0, Q30_ONE})) begin
            sum = $signed({1'b0, Q30_ONE});
        end
        return sum[63:0];
    endfunction

    function automatic sine_tab_t build_sine_table();
        sine_tab_t   tab;
        logic [63:0] k;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] s;
        logic [63:0] v;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            k    = 64'(i) * 64'd4;
            quad = k / SINE_ENTRIES;
            rem  = k % SINE_ENTRIES;
            s    = quad[0] ? quarter_sine(64'(SINE_ENTRIES) - rem) : quarter_sine(rem);
            v    = (quad < 64'd2) ? (Q30_ONE + s) : (Q30_ONE - s);
            tab[i] = 8'((64'd255 * v + Q30_ONE) >> 31);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

### design/rgbfx_front.sv
// rgbfx_front: input beat acceptance and command classification.
// Depends on rgbfx_pkg; feeds rgbfx_queue.
module rgbfx_front
    import rgbfx_pkg::*;
(
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_red_level,
    input  logic [7:0]  s_green_level,
    input  logic [7:0]  s_blue_level,
    input  logic [15:0] s_time_ms,
    input  logic        s_from_system,
    output logic        push_valid,
    input  logic        push_ready,
    output rgbfx_item_t push_item
);

    op_t op;

    always_comb begin
        case (s_command)
            CMD_TICK:                                   op = OP_TICK;
            CMD_STATIC, CMD_BLINK, CMD_PULSE, CMD_OFF:  op = OP_APPLY;
            CMD_RELEASE:                                op = OP_RELEASE;
            default:                                    op = OP_NONE;
        endcase
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_item.op          = op;
        push_item.cmd         = s_command;
        push_item.colour      = {s_red_level, s_green_level, s_blue_level};
        push_item.time_ms     = s_time_ms;
        push_item.from_system = s_from_system;
    end

endmodule

### design/rgbfx_queue.sv
// rgbfx_queue: short fifo of classified items between front and back.
// Depends on rgbfx_pkg for the item type.
module rgbfx_queue
    import rgbfx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  rgbfx_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output rgbfx_item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rgbfx_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### design/rgbfx_back.sv
// rgbfx_back: effect engine; applies commands, runs blink and pulse, owns the result register.
// Depends on rgbfx_pkg (types, codes, sine table).
module rgbfx_back
    import rgbfx_pkg::*;
#(
    parameter int BLINK_TOGGLES = SYSTEM_BLINK_TOGGLES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        q_valid,
    output logic        q_ready,
    input  rgbfx_item_t q_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_duty_red,
    output logic [7:0]  m_duty_green,
    output logic [7:0]  m_duty_blue,
    output logic [1:0]  m_effect_mode,
    output logic        m_override_active
);

    localparam int STEP_W = (SINE_IDX_W > 1) ? $clog2(SINE_IDX_W) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SCALE,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    effect_t                effect_reg, effect_next;
    logic [23:0]            colour_reg, colour_next;
    logic [15:0]            time_reg, time_next;
    logic                   manual_reg, manual_next;
    logic [15:0]            elapsed_reg, elapsed_next;
    logic                   lit_reg, lit_next;
    logic [2:0]             toggles_reg, toggles_next;
    logic [15:0]            phase_reg, phase_next;
    logic                   override_reg, override_next;
    logic [2:0]             saved_cmd_reg, saved_cmd_next;
    logic [23:0]            saved_colour_reg, saved_colour_next;
    logic [15:0]            saved_time_reg, saved_time_next;
    logic [23:0]            duty_reg, duty_next;
    logic [16:0]            rem_reg, rem_next;
    logic [SINE_IDX_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [15:0]            prod_r_reg, prod_r_next;
    logic [15:0]            prod_g_reg, prod_g_next;
    logic [15:0]            prod_b_reg, prod_b_next;
    logic                   anode_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [23:0]            m_duty_reg, m_duty_next;
    logic [1:0]             m_mode_reg, m_mode_next;
    logic                   m_ovr_reg, m_ovr_next;

    logic                   do_apply;
    logic [2:0]             a_cmd;
    logic [23:0]            a_colour;
    logic [15:0]            a_time;
    logic                   a_manual;
    logic                   eval_blink;
    logic                   eval_pulse;
    logic [16:0]            shifted;
    logic [15:0]            phase_inc;
    logic [7:0]             level;

    // exact floor(x / 255) for any x up to 255 * 255, the largest product of two 8-bit levels
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    assign cfg_ready = 1'b1;
    assign q_ready   = (state_reg == ST_IDLE);
    assign shifted   = {rem_reg[15:0], 1'b0};
    assign phase_inc = phase_reg + 16'd1;
    assign level     = SINE_TABLE[quot_reg];

    always_comb begin
        state_next        = state_reg;
        effect_next       = effect_reg;
        colour_next       = colour_reg;
        time_next         = time_reg;
        manual_next       = manual_reg;
        elapsed_next      = elapsed_reg;
        lit_next          = lit_reg;
        toggles_next      = toggles_reg;
        phase_next        = phase_reg;
        override_next     = override_reg;
        saved_cmd_next    = saved_cmd_reg;
        saved_colour_next = saved_colour_reg;
        saved_time_next   = saved_time_reg;
        duty_next         = duty_reg;
        rem_next          = rem_reg;
        quot_next         = quot_reg;
        step_next         = step_reg;
        prod_r_next       = prod_r_reg;
        prod_g_next       = prod_g_reg;
        prod_b_next       = prod_b_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_duty_next       = m_duty_reg;
        m_mode_next       = m_mode_reg;
        m_ovr_next        = m_ovr_reg;
        do_apply          = 1'b0;
        a_cmd             = q_item.cmd;
        a_colour          = q_item.colour;
        a_time            = q_item.time_ms;
        a_manual          = !q_item.from_system;
        eval_blink        = 1'b0;
        eval_pulse        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_item.op)
                        OP_TICK: begin
                            if (effect_reg == EFF_BLINK) begin
                                elapsed_next = elapsed_reg + 16'd1;
                                eval_blink   = 1'b1;
                            end else if (effect_reg == EFF_PULSE && time_reg != '0) begin
                                phase_next = (phase_inc >= time_reg) ? '0 : phase_inc;
                                eval_pulse = 1'b1;
                            end
                        end
                        OP_APPLY: begin
                            if (!q_item.from_system) begin
                                do_apply = 1'b1;
                            end else if (!override_reg) begin
                                do_apply          = 1'b1;
                                saved_cmd_next    = q_item.cmd;
                                saved_colour_next = q_item.colour;
                                saved_time_next   = q_item.time_ms;
                            end
                        end
                        OP_RELEASE: begin
                            do_apply = 1'b1;
                            a_cmd    = saved_cmd_reg;
                            a_colour = saved_colour_reg;
                            a_time   = saved_time_reg;
                            a_manual = 1'b0;
                        end
                        default: ;
                    endcase

                    if (do_apply) begin
                        override_next = a_manual;
                        manual_next   = a_manual;
                        colour_next   = a_colour;
                        time_next     = a_time;
                        elapsed_next  = '0;
                        phase_next    = '0;
                        lit_next      = 1'b1;
                        toggles_next  = '0;
                        case (a_cmd)
                            CMD_STATIC: begin
                                duty_next   = a_colour;
                                effect_next = EFF_NONE;
                            end
                            CMD_BLINK: begin
                                effect_next = EFF_BLINK;
                                eval_blink  = 1'b1;
                            end
                            CMD_PULSE: begin
                                effect_next = EFF_PULSE;
                                eval_pulse  = (a_time != '0);
                            end
                            default: begin
                                duty_next   = '0;
                                effect_next = EFF_NONE;
                            end
                        endcase
                    end

                    if (eval_blink && elapsed_next >= time_next) begin
                        elapsed_next = '0;
                        // system green blink runs a fixed number of toggles then goes dark
                        if (!manual_next && colour_next[15:8] == 8'hFF) begin
                            if (toggles_next < 3'(BLINK_TOGGLES)) begin
                                lit_next     = !lit_next;
                                duty_next    = lit_next ? 24'h00FF00 : 24'h000000;
                                toggles_next = toggles_next + 3'd1;
                            end else begin
                                effect_next = EFF_NONE;
                                duty_next   = '0;
                            end
                        end else begin
                            lit_next  = !lit_next;
                            duty_next = lit_next ? colour_next : 24'h000000;
                        end
                    end

                    rem_next   = {1'b0, phase_next};
                    quot_next  = '0;
                    step_next  = '0;
                    state_next = eval_pulse ? ST_DIV : ST_FINISH;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle: phase * entries / period
                if (shifted >= {1'b0, time_reg}) begin
                    rem_next  = shifted - {1'b0, time_reg};
                    quot_next = {quot_reg[SINE_IDX_W-2:0], 1'b1};
                end else begin
                    rem_next  = shifted;
                    quot_next = {quot_reg[SINE_IDX_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SINE_IDX_W - 1)) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_r_next = colour_reg[23:16] * level;
                prod_g_next = colour_reg[15:8] * level;
                prod_b_next = colour_reg[7:0] * level;
                state_next  = ST_SCALE;
            end
            ST_SCALE: begin
                duty_next  = {div255(prod_r_reg), div255(prod_g_reg), div255(prod_b_reg)};
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_duty_next  = anode_reg ? ~duty_reg : duty_reg;
                    m_mode_next  = effect_reg;
                    m_ovr_next   = override_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            effect_reg       <= EFF_NONE;
            colour_reg       <= '0;
            time_reg         <= '0;
            manual_reg       <= 1'b0;
            elapsed_reg      <= '0;
            lit_reg          <= 1'b0;
            toggles_reg      <= '0;
            phase_reg        <= '0;
            override_reg     <= 1'b0;
            saved_cmd_reg    <= CMD_STATIC;
            saved_colour_reg <= '0;
            saved_time_reg   <= '0;
            duty_reg         <= '0;
            anode_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            effect_reg       <= effect_next;
            colour_reg       <= colour_next;
            time_reg         <= time_next;
            manual_reg       <= manual_next;
            elapsed_reg      <= elapsed_next;
            lit_reg          <= lit_next;
            toggles_reg      <= toggles_next;
            phase_reg        <= phase_next;
            override_reg     <= override_next;
            saved_cmd_reg    <= saved_cmd_next;
            saved_colour_reg <= saved_colour_next;
            saved_time_reg   <= saved_time_next;
            duty_reg         <= duty_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_valid) begin
                anode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        step_reg   <= step_next;
        prod_r_reg <= prod_r_next;
        prod_g_reg <= prod_g_next;
        prod_b_reg <= prod_b_next;
        m_duty_reg <= m_duty_next;
        m_mode_reg <= m_mode_next;
        m_ovr_reg  <= m_ovr_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_duty_red        = m_duty_reg[23:16];
    assign m_duty_green      = m_duty_reg[15:8];
    assign m_duty_blue       = m_duty_reg[7:0];
    assign m_effect_mode     = m_mode_reg;
    assign m_override_active = m_ovr_reg;

    a_toggle_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        toggles_reg <= 3'(BLINK_TOGGLES))
        else $error("blink toggle count beyond limit");

    a_div_period: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> time_reg != '0)
        else $error("division started with zero period");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg == STEP_W'(SINE_IDX_W - 1)) |=> state_reg == ST_MUL)
        else $error("division did not finish after index width steps");

endmodule

### design/rgb_led_effect_controller.sv
// rgb_led_effect_controller: top level; front classifier, item queue and effect engine.
// An accepted beat is queued, taken by the engine in its idle state and registered as a result in its
// finish state; a pulse evaluation adds a restoring divide for the sine index, a multiply and a scale.
// The engine handles one item at a time and takes no new item until it has loaded the result register.
// Reset: synchronous active-low; levels black, no effect, no override, common cathode.
// Depends on rgbfx_pkg, rgbfx_front, rgbfx_queue and rgbfx_back.
module rgb_led_effect_controller
    import rgbfx_pkg::*;
#(
    parameter int BLINK_TOGGLES = SYSTEM_BLINK_TOGGLES,
    parameter int Q_DEPTH       = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_red_level,
    input  logic [7:0]  s_green_level,
    input  logic [7:0]  s_blue_level,
    input  logic [15:0] s_time_ms,
    input  logic        s_from_system,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_duty_red,
    output logic [7:0]  m_duty_green,
    output logic [7:0]  m_duty_blue,
    output logic [1:0]  m_effect_mode,
    output logic        m_override_active
);

    logic        push_valid, push_ready;
    rgbfx_item_t push_item;
    logic        q_valid, q_ready;
    rgbfx_item_t q_item;

    rgbfx_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_red_level   (s_red_level),
        .s_green_level (s_green_level),
        .s_blue_level  (s_blue_level),
        .s_time_ms     (s_time_ms),
        .s_from_system (s_from_system),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    rgbfx_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    rgbfx_back #(
        .BLINK_TOGGLES (BLINK_TOGGLES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .q_valid           (q_valid),
        .q_ready           (q_ready),
        .q_item            (q_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_duty_red        (m_duty_red),
        .m_duty_green      (m_duty_green),
        .m_duty_blue       (m_duty_blue),
        .m_effect_mode     (m_effect_mode),
        .m_override_active (m_override_active)
    );

endmodule

### tb/rgb_led_effect_controller_tb.sv
// rgb_led_effect_controller_tb: self-checking bench for the rgb led effect controller.
// Holds its own model of the effect engine and a scoreboard of expected duty beats.
// Depends on rgbfx_pkg and the design top level.
`timescale 1ns / 1ps

import rgbfx_pkg::*;

typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] mode;
    logic       ovr;
} led_state_t;

class led_scoreboard;
    logic [7:0]  sine_lut [SINE_ENTRIES];
    bit          anode;
    effect_t     effect;
    logic [23:0] colour;
    logic [15:0] period;
    bit          manual;
    logic [15:0] elapsed;
    bit          lit;
    logic [2:0]  toggles;
    logic [15:0] phase;
    bit          override_on;
    logic [2:0]  saved_cmd;
    logic [23:0] saved_colour;
    logic [15:0] saved_period;
    logic [23:0] levels;
    led_state_t  pending[$];
    int          errors;
    int          checked;

    function new();
        sine_lut = SINE_TABLE;
        anode = 0;
        effect = EFF_NONE;
        colour = '0;
        period = '0;
        manual = 0;
        elapsed = '0;
        lit = 0;
        toggles = '0;
        phase = '0;
        override_on = 0;
        saved_cmd = CMD_STATIC;
        saved_colour = '0;
        saved_period = '0;
        levels = '0;
        errors = 0;
        checked = 0;
    endfunction

    function void step_effect();
        int unsigned idx;
        int unsigned t;
        if (effect == EFF_BLINK) begin
            if (elapsed < period) return;
            elapsed = '0;
            if (!manual && colour[15:8] == 8'hff) begin
                if (toggles < SYSTEM_BLINK_TOGGLES) begin
                    lit = !lit;
                    levels = lit ? 24'h00ff00 : 24'h0;
                    toggles = toggles + 3'd1;
                end else begin
                    effect = EFF_NONE;
                    levels = '0;
                end
            end else begin
                lit = !lit;
                levels = lit ? colour : 24'h0;
            end
        end else if (effect == EFF_PULSE) begin
            if (period == 0) return;
            idx = 32'((64'(phase) * SINE_ENTRIES) / period);
            if (idx >= SINE_ENTRIES) idx = SINE_ENTRIES - 1;
            t = 32'(sine_lut[idx]);
            levels = {8'((colour[23:16] * t) / 255), 8'((colour[15:8] * t) / 255),
                      8'((colour[7:0] * t) / 255)};
        end
    endfunction

    function void start_command(logic [2:0] cmd, logic [23:0] col, logic [15:0] tm, bit man);
        override_on = man;
        manual = man;
        colour = col;
        period = tm;
        elapsed = '0;
        phase = '0;
        lit = 1;
        toggles = '0;
        case (cmd)
            CMD_STATIC: begin
                levels = col;
                effect = EFF_NONE;
            end
            CMD_BLINK: begin
                effect = EFF_BLINK;
                step_effect();
            end
            CMD_PULSE: begin
                effect = EFF_PULSE;
                step_effect();
            end
            default: begin
                levels = '0;
                effect = EFF_NONE;
            end
        endcase
    endfunction

    // note an accepted input beat and queue the duty beat it produces
    function void note_input(logic [2:0] cmd, logic [23:0] col, logic [15:0] tm, bit sys);
        led_state_t e;
        if (cmd == CMD_TICK) begin
            if (effect == EFF_BLINK) begin
                elapsed = elapsed + 16'd1;
                step_effect();
            end else if (effect == EFF_PULSE && period != 0) begin
                phase = phase + 16'd1;
                if (phase >= period) phase = '0;
                step_effect();
            end
        end else if (cmd <= CMD_OFF) begin
            if (!sys) begin
                start_command(cmd, col, tm, 1);
            end else if (!override_on) begin
                saved_cmd = cmd;
                saved_colour = col;
                saved_period = tm;
                start_command(cmd, col, tm, 0);
            end
        end else if (cmd == CMD_RELEASE) begin
            override_on = 0;
            start_command(saved_cmd, saved_colour, saved_period, 0);
        end
        e.red = anode ? 8'd255 - levels[23:16] : levels[23:16];
        e.green = anode ? 8'd255 - levels[15:8] : levels[15:8];
        e.blue = anode ? 8'd255 - levels[7:0] : levels[7:0];
        e.mode = effect;
        e.ovr = override_on;
        pending.push_back(e);
    endfunction

    task report(string what, int got, int want);
        $display("mismatch on %s: got %0d expected %0d (beat %0d)", what, got, want, checked);
        errors++;
    endtask

    task check_result(led_state_t got);
        led_state_t e;
        checked++;
        if (pending.size() == 0) begin
            $display("unexpected result beat %0d", checked);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.red !== e.red) report("duty_red", got.red, e.red);
        if (got.green !== e.green) report("duty_green", got.green, e.green);
        if (got.blue !== e.blue) report("duty_blue", got.blue, e.blue);
        if (got.mode !== e.mode) report("effect_mode", got.mode, e.mode);
        if (got.ovr !== e.ovr) report("override_active", got.ovr, e.ovr);
    endtask
endclass

module rgb_led_effect_controller_tb;
    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_command;
    logic [7:0]  s_red_level;
    logic [7:0]  s_green_level;
    logic [7:0]  s_blue_level;
    logic [15:0] s_time_ms;
    logic        s_from_system;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_duty_red;
    logic [7:0]  m_duty_green;
    logic [7:0]  m_duty_blue;
    logic [1:0]  m_effect_mode;
    logic        m_override_active;

    led_scoreboard board;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          sent;
    longint      cycles;
    led_state_t  seen;

    localparam longint CYCLE_LIMIT = 600000;

    rgb_led_effect_controller DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_red_level(s_red_level), .s_green_level(s_green_level),
        .s_blue_level(s_blue_level), .s_time_ms(s_time_ms), .s_from_system(s_from_system),
        .m_valid(m_valid), .m_ready(m_ready), .m_duty_red(m_duty_red),
        .m_duty_green(m_duty_green), .m_duty_blue(m_duty_blue),
        .m_effect_mode(m_effect_mode), .m_override_active(m_override_active)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        cycles = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("rgb_led_effect_controller test failed");
            $finish;
        end
    end

    // result side: sample accepted beats, randomise ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen.red = m_duty_red;
            seen.green = m_duty_green;
            seen.blue = m_duty_blue;
            seen.mode = m_effect_mode;
            seen.ovr = m_override_active;
            board.check_result(seen);
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays up after a beat; it drops only on an idle cycle or in drain
    task send_beat(logic [2:0] cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                   logic [15:0] tm, bit sys);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_red_level <= r;
        s_green_level <= g;
        s_blue_level <= b;
        s_time_ms <= tm;
        s_from_system <= sys;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(cmd, {r, g, b}, tm, sys);
        sent++;
    endtask

    task drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task write_polarity(bit v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        board.anode = v;
        cfg_valid <= 1'b0;
    endtask

    task tick_run(int n);
        repeat (n) send_beat(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                             16'($urandom), 1'($urandom));
    endtask

    // mostly ticks to watch the effects evolve, mixed with meaningful commands with mostly short periods
    task random_beat();
        logic [2:0]  cmd;
        logic [15:0] tm;
        logic [7:0]  g;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 60) cmd = CMD_TICK;
        else if (pick < 68) cmd = CMD_STATIC;
        else if (pick < 78) cmd = CMD_BLINK;
        else if (pick < 88) cmd = CMD_PULSE;
        else if (pick < 92) cmd = CMD_OFF;
        else if (pick < 97) cmd = CMD_RELEASE;
        else cmd = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 80) tm = 16'($urandom_range(8));
        else if (pick < 95) tm = 16'($urandom_range(300));
        else tm = 16'($urandom);
        g = ($urandom_range(3) == 0) ? 8'hff : 8'($urandom);
        send_beat(cmd, 8'($urandom), g, 8'($urandom), tm, $urandom_range(99) < 60);
    endtask

    initial begin
        board = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        s_valid = 1'b0;
        s_command = CMD_TICK;
        s_red_level = '0;
        s_green_level = '0;
        s_blue_level = '0;
        s_time_ms = '0;
        s_from_system = 1'b0;
        m_ready = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, each command and the corner cases
        send_beat(CMD_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0);
        send_beat(CMD_STATIC, 8'hff, 8'hff, 8'hff, 16'hffff, 1'b1);
        send_beat(CMD_BLINK, 8'h00, 8'hff, 8'h00, 16'd1, 1'b1);
        tick_run(16);
        send_beat(CMD_BLINK, 8'h12, 8'h34, 8'h56, 16'd0, 1'b1);
        tick_run(2);
        send_beat(CMD_PULSE, 8'hff, 8'h80, 8'h01, 16'd0, 1'b1);
        tick_run(1);
        send_beat(CMD_PULSE, 8'hff, 8'hff, 8'hff, 16'd3, 1'b0);
        send_beat(CMD_STATIC, 8'haa, 8'h55, 8'h0f, 16'd0, 1'b1);
        send_beat(CMD_OFF, 8'hff, 8'hff, 8'hff, 16'd9, 1'b1);
        send_beat(CMD_RELEASE, 8'hff, 8'h00, 8'hff, 16'hffff, 1'b0);
        send_beat(3'd6, 8'h00, 8'h00, 8'h00, 16'd0, 1'b1);
        send_beat(3'd7, 8'hff, 8'hff, 8'hff, 16'hffff, 1'b0);
        send_beat(CMD_PULSE, 8'hc8, 8'h64, 8'h20, 16'hffff, 1'b1);
        tick_run(2);
        write_polarity(1'b1);
        tick_run(2);
        send_beat(CMD_OFF, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0);
        write_polarity(1'b0);

        send_idle_pct = 15;
        recv_idle_pct = 58;
        repeat (500) random_beat();
        write_polarity(1'b1);
        // long receiver stall while the sender keeps offering
        hold_cycles = 300;
        repeat (200) random_beat();
        drain();
        send_idle_pct = 58;
        recv_idle_pct = 15;
        repeat (450) random_beat();
        write_polarity(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (450) random_beat();
        drain();
        write_polarity(1'b1);
        write_polarity(1'b0);

        $display("sent %0d input beats and checked %0d results across both polarities",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("rgb_led_effect_controller test passed");
        end else begin
            $display("rgb_led_effect_controller test failed");
        end
        $finish;
    end
endmodule
